// ===== design/aprepl_pkg.sv =====
// Package for the aging page replacement unit.
// Holds the table sizes, the outcome and register codes and the word types.
// No dependencies.
package aprepl_pkg;

    // Table geometry.
    localparam int FRAMES     = 16;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_W     = 20;
    localparam int AGE_W      = 8;
    localparam int FIDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FILL_W     = $clog2(FRAMES + 1);

    // Field widths of the word formats.
    localparam int ADDR_W    = 32;
    localparam int OUTCOME_W = 2;
    localparam int FRAME_W   = 4;

    // Configuration port.
    localparam int FIU_W      = 5;
    localparam int PERIOD_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_PERIOD = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [FIU_W-1:0]    FIU_RESET    = 5'd16;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd8;

    // Top bit that a referenced frame shifts into its age.
    localparam logic [AGE_W-1:0] AGE_TOP = 8'h80;

    // Outcome codes.
    localparam logic [OUTCOME_W-1:0] OUT_HIT         = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_FILL        = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_EVICT_CLEAN = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_EVICT_DIRTY = 2'd3;

    // Input word: one memory access.
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              is_write;
    } in_word_t;

    // Output word: what the access did to the frame table.
    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [FRAME_W-1:0]   frame;
        logic [PAGE_W-1:0]    evicted_page;
    } out_word_t;

    // One step of the victim search, from the sequencer to the comparator.
    typedef struct packed {
        logic              en;
        logic              start;
        logic [FIDX_W-1:0] idx;
        logic [AGE_W-1:0]  age;
        logic              dirty;
    } victim_step_t;

endpackage

// ===== design/aprepl_victim.sv =====
// Victim tracker of the aging page replacement unit: the shared age comparator.
// Takes one candidate frame per step and keeps the best eviction choice so far.
// Depends on aprepl_pkg.
module aprepl_victim (
    input  logic                           clk,
    input  logic                           rst_n,
    input  aprepl_pkg::victim_step_t       step,
    output logic [aprepl_pkg::FIDX_W-1:0]  best_idx
);
    import aprepl_pkg::*;

    logic [FIDX_W-1:0] best_idx_reg;
    logic [AGE_W-1:0]  best_age_reg;
    logic              best_dirty_reg;
    logic              have_best_reg;
    logic              take;

    // A candidate wins with a smaller age, or with an equal age when it is clean.
    // The first step of a search always loads the candidate.
    always_comb
    begin
        take = step.start
            || (step.age < best_age_reg)
            || ((step.age == best_age_reg) && !step.dirty);
    end

    // Best choice so far.
    always_ff @(posedge clk)
    begin
        if (step.en && take)
        begin
            best_idx_reg   <= step.idx;
            best_age_reg   <= step.age;
            best_dirty_reg <= step.dirty;
        end
    end

    // Marks that a search has been started since reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_best_reg <= 1'b0;
        end
        else if (step.en && step.start)
        begin
            have_best_reg <= 1'b1;
        end
    end

    assign best_idx = best_idx_reg;

    // A search starts from its first candidate.
    a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        step.en && step.start |=> best_idx_reg == $past(step.idx))
        else $error("victim search did not start from its first candidate");

    // The best age never grows during a search.
    a_age_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        step.en && !step.start && have_best_reg |=> best_age_reg <= $past(best_age_reg))
        else $error("best age grew during a victim search");

    // A strictly younger frame always takes over.
    a_younger_wins: assert property (@(posedge clk) disable iff (!rst_n)
        step.en && !step.start && have_best_reg && (step.age < best_age_reg)
        |=> best_idx_reg == $past(step.idx))
        else $error("younger frame was not chosen as victim");

    // A clean frame of equal age always takes over.
    a_clean_tie_wins: assert property (@(posedge clk) disable iff (!rst_n)
        step.en && !step.start && have_best_reg && (step.age == best_age_reg) && !step.dirty
        |=> best_dirty_reg == 1'b0)
        else $error("clean frame of equal age was not chosen as victim");

endmodule

// ===== design/aging_page_replacement_unit.sv =====
// Top level of the aging page replacement unit: sequencer, frame table, config.
// Depends on aprepl_pkg and aprepl_victim.
//
// The unit takes one access word at a time and returns one result word per access.
// The frame table and its one age comparator are walked one frame per cycle. An
// accepted access first runs an aging pass over the filled frames when one is due,
// then a lookup that probes the filled frames until a hit. A miss with no free
// usable frame then runs a victim search over the usable frames and an eviction.
// The result word is then registered, and the next access word can be accepted in
// the cycle after that; a finished result first waits for the output register to
// empty. A new access is accepted while the previous result still waits in the
// output register. The user must write configuration only while idle; the block
// itself does not enforce it.
// No clearing pass runs after reset; the unit is ready at once.
module aging_page_replacement_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // Access words.
    input  logic                              in_valid,
    output logic                              in_ready,
    input  aprepl_pkg::in_word_t              in_data,
    // Result words.
    output logic                              out_valid,
    input  logic                              out_ready,
    output aprepl_pkg::out_word_t             out_data,
    // Configuration writes.
    input  logic                              cfg_we,
    input  logic [aprepl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aprepl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import aprepl_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_AGE    = 6'b000010,
        S_LOOK   = 6'b000100,
        S_SEARCH = 6'b001000,
        S_EVICT  = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [FIDX_W-1:0]     idx_reg, idx_next;
    logic [PAGE_W-1:0]     page_reg, page_next;
    logic                  wr_reg, wr_next;
    logic                  aging_reg, aging_next;
    logic [FILL_W-1:0]     filled_reg, filled_next;
    logic [PERIOD_W-1:0]   count_reg, count_next;
    logic [FIU_W-1:0]      fiu_reg, fiu_next;
    logic [PERIOD_W-1:0]   period_reg, period_next;
    logic [FRAMES-1:0]     ref_reg, ref_next;
    logic [FRAMES-1:0]     dirty_reg, dirty_next;
    logic                  out_valid_reg, out_valid_next;
    out_word_t             res_reg, res_next;
    out_word_t             out_data_reg;

    // Frame table storage; entries are read only once filled.
    logic [PAGE_W-1:0]     page_mem [FRAMES];
    logic [AGE_W-1:0]      age_mem  [FRAMES];

    logic                  in_fire;
    logic                  out_fire;
    logic                  out_load;
    logic [FILL_W-1:0]     idx_plus;
    logic [FILL_W-1:0]     lim;
    logic                  last_filled;
    logic                  last_lim;
    logic                  page_hit;
    logic [PERIOD_W:0]     count_plus;
    logic [PERIOD_W:0]     period_eff;
    logic [FIDX_W-1:0]     victim_idx;
    victim_step_t          vstep;

    // Table write controls.
    logic                  age_we;
    logic [AGE_W-1:0]      age_wdata;
    logic                  load_we;
    logic [FIDX_W-1:0]     load_idx;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // Frame index helpers.
    assign idx_plus    = FILL_W'(idx_reg) + FILL_W'(1);
    assign last_filled = (idx_plus == filled_reg);
    assign last_lim    = (idx_plus == lim);
    assign page_hit    = (page_mem[idx_reg] == page_reg);

    // Usable frames: zero counts as one, anything above the table size as the size.
    always_comb
    begin
        if (fiu_reg == '0)
        begin
            lim = FILL_W'(1);
        end
        else if (int'(fiu_reg) > FRAMES)
        begin
            lim = FILL_W'(FRAMES);
        end
        else
        begin
            lim = FILL_W'(fiu_reg);
        end
    end

    // Refresh counter step; a zero period counts as one.
    assign count_plus = {1'b0, count_reg} + {{PERIOD_W{1'b0}}, 1'b1};
    assign period_eff = (period_reg == '0) ? {{PERIOD_W{1'b0}}, 1'b1} : {1'b0, period_reg};

    // Candidate handed to the age comparator while searching.
    always_comb
    begin
        vstep.en    = (state_reg == S_SEARCH);
        vstep.start = (idx_reg == '0);
        vstep.idx   = idx_reg;
        vstep.age   = age_mem[idx_reg];
        vstep.dirty = dirty_reg[idx_reg];
    end

    aprepl_victim u_victim (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (vstep),
        .best_idx (victim_idx)
    );

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        page_next   = page_reg;
        wr_next     = wr_reg;
        aging_next  = aging_reg;
        filled_next = filled_reg;
        count_next  = count_reg;
        ref_next    = ref_reg;
        dirty_next  = dirty_reg;
        res_next    = res_reg;
        age_we      = 1'b0;
        age_wdata   = (age_mem[idx_reg] >> 1) | (ref_reg[idx_reg] ? AGE_TOP : '0);
        load_we     = 1'b0;
        load_idx    = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    page_next  = PAGE_W'(in_data.address >> PAGE_SHIFT);
                    wr_next    = in_data.is_write;
                    aging_next = (count_reg == '0);
                    count_next = (count_plus >= period_eff) ? '0 : count_plus[PERIOD_W-1:0];
                    idx_next   = '0;
                    state_next = (count_reg == '0) ? S_AGE : S_LOOK;
                end
            end

            // Aging pass over the filled frames.
            S_AGE:
            begin
                if (filled_reg == '0)
                begin
                    state_next = S_LOOK;
                end
                else
                begin
                    age_we            = 1'b1;
                    ref_next[idx_reg] = 1'b0;
                    if (last_filled)
                    begin
                        idx_next   = '0;
                        state_next = S_LOOK;
                    end
                    else
                    begin
                        idx_next = idx_reg + FIDX_W'(1);
                    end
                end
            end

            // Lookup over the filled frames, then hit, fill or start a search.
            S_LOOK:
            begin
                if ((filled_reg != '0) && page_hit)
                begin
                    ref_next[idx_reg] = 1'b1;
                    if (wr_reg)
                    begin
                        dirty_next[idx_reg] = 1'b1;
                    end
                    res_next.outcome      = OUT_HIT;
                    res_next.frame        = FRAME_W'(idx_reg);
                    res_next.evicted_page = '0;
                    state_next            = S_DONE;
                end
                else if ((filled_reg == '0) || last_filled)
                begin
                    if (filled_reg < lim)
                    begin
                        load_we                         = 1'b1;
                        load_idx                        = FIDX_W'(filled_reg);
                        ref_next[FIDX_W'(filled_reg)]   = 1'b1;
                        dirty_next[FIDX_W'(filled_reg)] = wr_reg;
                        filled_next                     = filled_reg + FILL_W'(1);
                        res_next.outcome                = OUT_FILL;
                        res_next.frame                  = FRAME_W'(filled_reg);
                        res_next.evicted_page           = '0;
                        state_next                      = S_DONE;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_SEARCH;
                    end
                end
                else
                begin
                    idx_next = idx_reg + FIDX_W'(1);
                end
            end

            // Victim search over the usable frames.
            S_SEARCH:
            begin
                if (last_lim)
                begin
                    state_next = S_EVICT;
                end
                else
                begin
                    idx_next = idx_reg + FIDX_W'(1);
                end
            end

            // Replace the chosen frame.
            S_EVICT:
            begin
                res_next.outcome      = dirty_reg[victim_idx] ? OUT_EVICT_DIRTY
                                                              : OUT_EVICT_CLEAN;
                res_next.frame        = FRAME_W'(victim_idx);
                res_next.evicted_page = page_mem[victim_idx];
                load_we               = 1'b1;
                load_idx              = victim_idx;
                ref_next[victim_idx]   = 1'b1;
                dirty_next[victim_idx] = wr_reg;
                state_next            = S_DONE;
            end

            // Hand the result to the output register.
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Configuration registers.
    always_comb
    begin
        fiu_next    = fiu_reg;
        period_next = period_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAMES_IN_USE:  fiu_next    = cfg_data[FIU_W-1:0];
                CFG_REFRESH_PERIOD: period_next = cfg_data[PERIOD_W-1:0];
                default:            fiu_next    = fiu_reg;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            aging_reg     <= 1'b0;
            filled_reg    <= '0;
            count_reg     <= '0;
            fiu_reg       <= FIU_RESET;
            period_reg    <= PERIOD_RESET;
            ref_reg       <= '0;
            dirty_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            aging_reg     <= aging_next;
            filled_reg    <= filled_next;
            count_reg     <= count_next;
            fiu_reg       <= fiu_next;
            period_reg    <= period_next;
            ref_reg       <= ref_next;
            dirty_reg     <= dirty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
        wr_reg   <= wr_next;
        res_reg  <= res_next;
        if (out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    // Frame table writes.
    always_ff @(posedge clk)
    begin
        if (age_we)
        begin
            age_mem[idx_reg] <= age_wdata;
        end
        if (load_we)
        begin
            page_mem[load_idx] <= page_reg;
            age_mem[load_idx]  <= '0;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Aging passes only ever start on accesses that found the counter at zero.
    a_age_when_due: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AGE) |-> aging_reg)
        else $error("aging pass ran without being due");

    // The fill count never exceeds the table size.
    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= FILL_W'(FRAMES))
        else $error("fill count exceeds the frame table");

    // A hit or a fill reports no evicted page.
    a_no_evict_page: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ((out_data_reg.outcome == OUT_HIT) || (out_data_reg.outcome == OUT_FILL))
        |-> out_data_reg.evicted_page == '0)
        else $error("evicted page reported without an eviction");

    // A finished result waits while the output register is still full.
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && out_valid_reg && !out_ready |=> state_reg == S_DONE)
        else $error("result overwrote a word not yet taken");

endmodule
